FILE: hw/rtl/hmmd_pkg.sv
// ----------------------------------------------------------------------------
// hmmd_pkg
// Shared types and constants of the handheld memory map decoder: target
// codes, address boundaries, register indexes and controller commands.
// ----------------------------------------------------------------------------
package hmmd_pkg;

	// Target codes.
	localparam logic [3:0] TGT_CART     = 4'd0;
	localparam logic [3:0] TGT_BOOT     = 4'd1;
	localparam logic [3:0] TGT_CBOOT    = 4'd2;
	localparam logic [3:0] TGT_VRAM     = 4'd3;
	localparam logic [3:0] TGT_WRAM     = 4'd4;
	localparam logic [3:0] TGT_OAM      = 4'd5;
	localparam logic [3:0] TGT_UNUSABLE = 4'd6;
	localparam logic [3:0] TGT_JOYPAD   = 4'd7;
	localparam logic [3:0] TGT_TIMER    = 4'd8;
	localparam logic [3:0] TGT_AUDIO    = 4'd9;
	localparam logic [3:0] TGT_VIDEO    = 4'd10;
	localparam logic [3:0] TGT_IRQ      = 4'd11;
	localparam logic [3:0] TGT_BANKREG  = 4'd12;
	localparam logic [3:0] TGT_HRAM     = 4'd13;
	localparam logic [3:0] TGT_UNMAPPED = 4'd14;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CART_PRESENT = 1'd1;

	// I/O register indexes and ranges (low byte of the address).
	localparam logic [7:0] REG_JOYPAD = 8'h00;
	localparam logic [7:0] REG_IF     = 8'h0F;
	localparam logic [7:0] REG_IE     = 8'hFF;
	localparam logic [7:0] REG_VBK    = 8'h4F;
	localparam logic [7:0] REG_BOOT   = 8'h50;
	localparam logic [7:0] REG_SVBK   = 8'h70;
	localparam logic [7:0] TIMER_LO   = 8'd4;
	localparam logic [7:0] TIMER_HI   = 8'd7;
	localparam logic [7:0] AUDIO_LO   = 8'd16;
	localparam logic [7:0] AUDIO_HI   = 8'd63;
	localparam logic [7:0] VIDEO_LO   = 8'd64;
	localparam logic [7:0] VIDEO_HI   = 8'd75;

	// Address boundaries.
	localparam logic [15:0] BOOT_END    = 16'h00FF;
	localparam logic [15:0] CBOOT_START = 16'h0200;
	localparam logic [15:0] CBOOT_END   = 16'h07FF;
	localparam logic [15:0] ECHO_END    = 16'hFDFF;
	localparam logic [15:0] OAM_START   = 16'hFE00;
	localparam logic [15:0] OAM_END     = 16'hFE9F;
	localparam logic [15:0] UNUSE_START = 16'hFEA0;
	localparam logic [15:0] UNUSE_END   = 16'hFEFF;
	localparam logic [15:0] IO_END      = 16'hFF7F;
	localparam logic [15:0] IE_ADDR     = 16'hFFFF;
	localparam logic [15:0] HRAM_START  = 16'hFF80;

	localparam logic [3:0] REGION_VRAM0 = 4'h8;
	localparam logic [3:0] REGION_VRAM1 = 4'h9;
	localparam logic [3:0] REGION_XRAM0 = 4'hA;
	localparam logic [3:0] REGION_XRAM1 = 4'hB;
	localparam logic [3:0] REGION_ROM_LAST = 4'h7;

	// Stores.
	localparam int WRAM_DEPTH = 32768;
	localparam int WRAM_AW    = 15;
	localparam int HRAM_DEPTH = 127;
	localparam int HRAM_AW    = 7;

	localparam logic [7:0] NO_CART_DATA = 8'hFF;

	// Decoded access.
	typedef struct packed {
		logic [3:0]         target;
		logic [15:0]        loc;
		logic [7:0]         rd;
		logic               own;
		logic               sel_wram;
		logic               sel_hram;
		logic               wram_we;
		logic [WRAM_AW-1:0] wram_idx;
		logic               hram_we;
		logic [HRAM_AW-1:0] hram_idx;
		logic               vbk_we;
		logic               boot_we;
		logic               svbk_we;
	} dec_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic               clr;
		logic               clr_hram;
		logic [WRAM_AW-1:0] clr_idx;
		logic               acc;
		logic               adv;
	} cmd_t;

endpackage

FILE: hw/rtl/hmmd_ctrl.sv
// ----------------------------------------------------------------------------
// hmmd_ctrl
// Controller: clearing sweep after reset, stage valid flags and handshakes.
// ----------------------------------------------------------------------------
module hmmd_ctrl import hmmd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);

	localparam logic ST_CLEAR = 1'b0;
	localparam logic ST_RUN   = 1'b1;

	logic               state_q;
	logic [WRAM_AW-1:0] clr_cnt_q;
	logic               s1_valid_q;
	logic               out_valid_q;
	logic               adv;
	logic               acc;

	// The first stage moves on when the output register is empty or is being taken.
	assign adv      = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = (state_q != ST_RUN) || (s1_valid_q && !adv);
	assign acc      = in_valid && !in_stall;

	assign out_valid     = out_valid_q;
	assign cmd.clr       = (state_q == ST_CLEAR);
	assign cmd.clr_hram  = (state_q == ST_CLEAR) &&
		(clr_cnt_q < WRAM_AW'(HRAM_DEPTH));
	assign cmd.clr_idx   = clr_cnt_q;
	assign cmd.acc       = acc;
	assign cmd.adv       = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == WRAM_AW'(WRAM_DEPTH - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/hmmd_decode.sv
// ----------------------------------------------------------------------------
// hmmd_decode
// Address decoder: picks the target, translates the address and works out
// which store or register the access touches.
// ----------------------------------------------------------------------------
module hmmd_decode import hmmd_pkg::*; (
	input  logic        mode,
	input  logic [15:0] address,
	input  logic [2:0]  work_bank,
	input  logic        video_bank,
	input  logic        boot_off,
	input  logic        color_mode,
	input  logic        cart_present,
	output dec_t        dec
);

	logic [3:0] region;
	logic [7:0] reg_idx;
	logic [2:0] bank;
	logic       wr;

	assign region  = address[15:12];
	assign reg_idx = address[7:0];
	assign wr      = mode;
	// The upper work RAM window and its echo use the switched bank.
	assign bank    = address[12] ? work_bank : 3'd0;

	always_comb begin
		dec          = '0;
		dec.target   = TGT_UNMAPPED;
		dec.loc      = address;
		dec.wram_idx = {bank, address[11:0]};
		dec.hram_idx = HRAM_AW'(address - HRAM_START);
		if (region <= REGION_ROM_LAST || region == REGION_XRAM0 ||
			region == REGION_XRAM1) begin
			dec.target = TGT_CART;
			if (wr) begin
				dec.target = TGT_CART;
			end else if (!boot_off && address <= BOOT_END) begin
				dec.target = TGT_BOOT;
			end else if (!boot_off && color_mode && address >= CBOOT_START &&
				address <= CBOOT_END) begin
				dec.target = TGT_CBOOT;
				dec.loc    = address - CBOOT_START;
			end else if (!cart_present) begin
				dec.rd  = NO_CART_DATA;
				dec.own = 1'b1;
			end
		end else if (region == REGION_VRAM0 || region == REGION_VRAM1) begin
			dec.target = TGT_VRAM;
			dec.loc    = {2'b00, video_bank, address[12:0]};
		end else if (address <= ECHO_END) begin
			dec.target   = TGT_WRAM;
			dec.loc      = {1'b0, bank, address[11:0]};
			dec.wram_we  = wr;
			dec.sel_wram = !wr;
			dec.own      = !wr;
		end else if (address <= OAM_END) begin
			dec.target = TGT_OAM;
			dec.loc    = address - OAM_START;
		end else if (address <= UNUSE_END) begin
			dec.target = TGT_UNUSABLE;
			dec.loc    = address - UNUSE_START;
			dec.own    = !wr;
		end else if (address <= IO_END || address == IE_ADDR) begin
			dec.loc = {8'h00, reg_idx};
			if (reg_idx == REG_JOYPAD) begin
				dec.target = TGT_JOYPAD;
			end else if (reg_idx >= TIMER_LO && reg_idx <= TIMER_HI) begin
				dec.target = TGT_TIMER;
			end else if (reg_idx >= AUDIO_LO && reg_idx <= AUDIO_HI) begin
				dec.target = TGT_AUDIO;
			end else if (reg_idx >= VIDEO_LO && reg_idx <= VIDEO_HI) begin
				dec.target = TGT_VIDEO;
			end else if (reg_idx == REG_IF || reg_idx == REG_IE) begin
				dec.target = TGT_IRQ;
			end else if (reg_idx == REG_VBK || reg_idx == REG_BOOT ||
				reg_idx == REG_SVBK) begin
				dec.target  = TGT_BANKREG;
				dec.own     = !wr;
				dec.vbk_we  = wr && (reg_idx == REG_VBK);
				dec.boot_we = wr && (reg_idx == REG_BOOT);
				dec.svbk_we = wr && (reg_idx == REG_SVBK);
				if (!wr && reg_idx == REG_VBK) begin
					dec.rd = {7'd0, video_bank};
				end else if (!wr && reg_idx == REG_SVBK) begin
					dec.rd = {5'd0, work_bank};
				end
			end else begin
				dec.target = TGT_UNMAPPED;
				dec.own    = !wr;
			end
		end else begin
			dec.target   = TGT_HRAM;
			dec.loc      = address - HRAM_START;
			dec.hram_we  = wr;
			dec.sel_hram = !wr;
			dec.own      = !wr;
		end
	end

endmodule

FILE: hw/rtl/hmmd_datapath.sv
// ----------------------------------------------------------------------------
// hmmd_datapath
// Datapath: configuration and bank registers, work RAM and high RAM, the
// first pipeline stage and the output register.
// ----------------------------------------------------------------------------
module hmmd_datapath import hmmd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [0:0]           cfg_data,
	input  logic                 mode,
	input  logic [15:0]          address,
	input  logic [7:0]           write_data,
	output logic [3:0]           target,
	output logic [15:0]          local_address,
	output logic [7:0]           read_data,
	output logic                 data_from_block
);

	logic [2:0] work_bank_q;
	logic       video_bank_q;
	logic       boot_off_q;
	logic       color_mode_q;
	logic       cart_present_q;
	dec_t       dec;

	logic [7:0]         wram_mem [WRAM_DEPTH];
	logic [7:0]         hram_mem [HRAM_DEPTH];
	logic [WRAM_AW-1:0] wram_addr;
	logic               wram_we;
	logic [7:0]         wram_wd;
	logic [HRAM_AW-1:0] hram_addr;
	logic               hram_we;
	logic [7:0]         hram_wd;
	logic [7:0]         wram_rd_s1;
	logic [7:0]         hram_rd_s1;

	logic [3:0]  target_s1;
	logic [15:0] loc_s1;
	logic [7:0]  rd_s1;
	logic        own_s1;
	logic        sel_wram_s1;
	logic        sel_hram_s1;

	logic [3:0]  target_q;
	logic [15:0] loc_q;
	logic [7:0]  rd_q;
	logic        own_q;

	hmmd_decode u_decode (
		.mode         (mode),
		.address      (address),
		.work_bank    (work_bank_q),
		.video_bank   (video_bank_q),
		.boot_off     (boot_off_q),
		.color_mode   (color_mode_q),
		.cart_present (cart_present_q),
		.dec          (dec)
	);

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q   <= 1'b0;
			cart_present_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_COLOR_MODE:   color_mode_q   <= cfg_data[0];
				CFG_CART_PRESENT: cart_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Bank and boot registers change at the edge that accepts the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_bank_q  <= 3'd1;
			video_bank_q <= 1'b0;
			boot_off_q   <= 1'b0;
		end else if (cmd.acc) begin
			if (dec.vbk_we) begin
				video_bank_q <= write_data[0];
			end
			if (dec.boot_we) begin
				boot_off_q <= write_data[0];
			end
			if (dec.svbk_we) begin
				work_bank_q <= (write_data[2:0] == 3'd0) ? 3'd1 : write_data[2:0];
			end
		end
	end

	// The clearing sweep shares the single port of each store.
	assign wram_addr = cmd.clr ? cmd.clr_idx : dec.wram_idx;
	assign wram_we   = cmd.clr || (cmd.acc && dec.wram_we);
	assign wram_wd   = cmd.clr ? 8'h00 : write_data;
	assign hram_addr = cmd.clr ? cmd.clr_idx[HRAM_AW-1:0] : dec.hram_idx;
	assign hram_we   = cmd.clr_hram || (cmd.acc && dec.hram_we);
	assign hram_wd   = cmd.clr ? 8'h00 : write_data;

	always_ff @(posedge clk) begin
		if (wram_we) begin
			wram_mem[wram_addr] <= wram_wd;
		end
		if (cmd.acc) begin
			wram_rd_s1 <= wram_mem[wram_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (hram_we) begin
			hram_mem[hram_addr] <= hram_wd;
		end
		if (cmd.acc) begin
			hram_rd_s1 <= hram_mem[hram_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			target_s1   <= dec.target;
			loc_s1      <= dec.loc;
			rd_s1       <= dec.rd;
			own_s1      <= dec.own;
			sel_wram_s1 <= dec.sel_wram;
			sel_hram_s1 <= dec.sel_hram;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.adv) begin
			target_q <= target_s1;
			loc_q    <= loc_s1;
			own_q    <= own_s1;
			if (sel_wram_s1) begin
				rd_q <= wram_rd_s1;
			end else if (sel_hram_s1) begin
				rd_q <= hram_rd_s1;
			end else begin
				rd_q <= rd_s1;
			end
		end
	end

	assign target          = target_q;
	assign local_address   = loc_q;
	assign read_data       = rd_q;
	assign data_from_block = own_q;

endmodule

FILE: hw/rtl/handheld_memory_map_decoder.sv
// ----------------------------------------------------------------------------
// handheld_memory_map_decoder
// CPU bus decoder with banked work RAM, high RAM and bank/boot registers.
// ----------------------------------------------------------------------------
// After reset the block clears work RAM and high RAM, one entry per cycle,
// and holds in_stall high during that sweep. It then takes one transaction
// per cycle while the first stage is empty or moving on: the store access and
// register update happen at the accepting edge, the stored read data is
// captured in the first stage, and the result then moves into the output
// register and is shown on out_valid. The single port of the work RAM, used
// once per transaction, sets that rate. A result waiting on out_stall does
// not stop one further transaction from being accepted into the first stage.
module handheld_memory_map_decoder import hmmd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [0:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [15:0]          address,
	input  logic [7:0]           write_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           target,
	output logic [15:0]          local_address,
	output logic [7:0]           read_data,
	output logic                 data_from_block
);

	cmd_t cmd;

	hmmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	hmmd_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mode            (mode),
		.address         (address),
		.write_data      (write_data),
		.target          (target),
		.local_address   (local_address),
		.read_data       (read_data),
		.data_from_block (data_from_block)
	);

	// No transaction may enter while the stores are being cleared.
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> in_stall)
		else $error("transaction accepted during clearing sweep");

	// Data not supplied by this block must read as zero.
	a_foreign_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !data_from_block) |-> (read_data == 8'h00))
		else $error("nonzero read_data on a result not owned by the block");

	// Video RAM and OAM accesses are always answered by their targets.
	a_vram_oam_foreign: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (target == TGT_VRAM || target == TGT_OAM)) |-> !data_from_block)
		else $error("video RAM or OAM result marked as block data");

endmodule
